// File: rtl/core/k_way_heap_merge_core_assert.svh
`ifndef K_WAY_HEAP_MERGE_CORE_ASSERT_SVH
`define K_WAY_HEAP_MERGE_CORE_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define KWHM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kwhm port check failed");

// next-cycle implication
`define KWHM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kwhm port check failed");

`endif

// File: rtl/core/kwhm_pkg.sv
package kwhm_pkg;

  localparam int MAX_ARRAYS_DEF = 16;
  localparam int VAL_W = 32;
  localparam int ARR_W = 4;
  localparam int CNT_W = 5;
  localparam int COUNT_LIMIT = 16;
  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [ARR_W-1:0]        source;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_WRAP,
    S_REPORT
  } state_t;

  // address source for read port a (port b always reads the right child)
  typedef enum logic [1:0] {
    RD_ROOT,
    RD_LAST,
    RD_PARENT,
    RD_LEFT
  } rd_sel_t;

  typedef struct packed {
    logic    latch_in;
    logic    emit_err;
    logic    fill_step;
    logic    push;
    logic    drop;
    logic    load_x;
    logic    wr_x;
    logic    up_move;
    logic    dn_move;
    logic    emit_report;
    rd_sel_t rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic req_err;
    logic merge_phase;
    logic cmd_end;
    logic heap_full;
    logic size_zero;
    logic size_one;
    logic at_root;
    logic x_less_a;
    logic child_moves;
    logic report_due;
  } dp_status_t;

endpackage

// File: rtl/core/k_way_heap_merge_core.sv
// sequence: a wrong-array transaction is decoded and its error result is registered;
// a fill head is decoded and, when inserted, rises one level per parent read and compare
// until a parent stops it or it reaches the root; the head that ends the fill goes on to the report.
// a merge item loads the root (the last entry on removal), sifts it down level by level,
// then wraps and reports; removing the last entry goes straight to the report. each level: ram read, then compare.
// busy stays high until the strobe, no stall from the receiver; reset empties the heap.
module k_way_heap_merge_core #(
  parameter int MAX_ARRAYS = kwhm_pkg::MAX_ARRAYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic signed [kwhm_pkg::VAL_W-1:0] element_value,
  input  logic [kwhm_pkg::ARR_W-1:0]        array_index,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kwhm_pkg::CNT_W-1:0]        cfg_data,
  output logic                              result_valid,
  output logic signed [kwhm_pkg::VAL_W-1:0] min_value,
  output logic [kwhm_pkg::ARR_W-1:0]        next_array,
  output logic                              done_res,
  output logic                              error
);
  import kwhm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes are meant only while idle; the block does not enforce it, and they are always taken
  assign cfg_ready = 1'b1;

  kwhm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  kwhm_dp #(
    .MAX_ARRAYS (MAX_ARRAYS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .command       (command),
    .element_value (element_value),
    .array_index   (array_index),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .min_value     (min_value),
    .next_array    (next_array),
    .done_res      (done_res),
    .error         (error)
  );

endmodule

// File: rtl/core/kwhm_ram.sv
module kwhm_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/core/kwhm_ctrl.sv
module kwhm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  kwhm_pkg::dp_status_t status,
  output logic                busy,
  output kwhm_pkg::dp_cmd_t   cmd
);
  import kwhm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (status.req_err) begin
          state_next = S_IDLE;
        end else if (!status.merge_phase) begin
          if (!status.cmd_end && !status.heap_full) state_next = S_UP_RD;
          else state_next = S_WRAP;
        end else if (status.size_zero) begin
          state_next = S_REPORT;
        end else if (status.cmd_end && status.size_one) begin
          state_next = S_REPORT;
        end else begin
          state_next = S_DN_LOAD;
        end
      end
      S_UP_RD: begin
        if (status.at_root) state_next = S_WRAP;
        else state_next = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (status.x_less_a) state_next = S_UP_RD;
        else state_next = S_WRAP;
      end
      S_DN_LOAD: state_next = S_DN_RD;
      S_DN_RD:   state_next = S_DN_CMP;
      S_DN_CMP: begin
        if (status.child_moves) state_next = S_DN_RD;
        else state_next = S_WRAP;
      end
      S_WRAP: begin
        if (status.report_due) state_next = S_REPORT;
        else state_next = S_IDLE;
      end
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy         = 1'b0;
        cmd.latch_in = start;
      end
      S_DECODE: begin
        if (status.req_err) begin
          cmd.emit_err = 1'b1;
        end else if (!status.merge_phase) begin
          cmd.fill_step = 1'b1;
          cmd.push      = !status.cmd_end && !status.heap_full;
        end else if (!status.size_zero) begin
          cmd.drop   = status.cmd_end;
          cmd.rd_sel = status.cmd_end ? RD_LAST : RD_ROOT;
        end
      end
      S_UP_RD: begin
        cmd.rd_sel = RD_PARENT;
        cmd.wr_x   = status.at_root;
      end
      S_UP_CMP: begin
        cmd.up_move = status.x_less_a;
        cmd.wr_x    = !status.x_less_a;
      end
      S_DN_LOAD: cmd.load_x = 1'b1;
      S_DN_RD:   cmd.rd_sel = RD_LEFT;
      S_DN_CMP: begin
        cmd.dn_move = status.child_moves;
        cmd.wr_x    = !status.child_moves;
      end
      S_WRAP:   cmd.rd_sel = RD_ROOT;
      S_REPORT: cmd.emit_report = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule

// File: rtl/core/kwhm_dp.sv
module kwhm_dp #(
  parameter int MAX_ARRAYS = kwhm_pkg::MAX_ARRAYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  kwhm_pkg::dp_cmd_t                 cmd,
  output kwhm_pkg::dp_status_t              status,
  input  logic                              command,
  input  logic signed [kwhm_pkg::VAL_W-1:0] element_value,
  input  logic [kwhm_pkg::ARR_W-1:0]        array_index,
  input  logic                              cfg_we,
  input  logic [kwhm_pkg::CNT_W-1:0]        cfg_data,
  output logic                              result_valid,
  output logic signed [kwhm_pkg::VAL_W-1:0] min_value,
  output logic [kwhm_pkg::ARR_W-1:0]        next_array,
  output logic                              done_res,
  output logic                              error
);
  import kwhm_pkg::*;

  localparam int IW  = $clog2(MAX_ARRAYS);
  localparam int SW  = $clog2(MAX_ARRAYS + 1);
  localparam int CIW = IW + 2;
  localparam int CAP = (MAX_ARRAYS < COUNT_LIMIT) ? MAX_ARRAYS : COUNT_LIMIT;

  // accepted transaction
  logic                    in_cmd;
  logic signed [VAL_W-1:0] in_val;
  logic [ARR_W-1:0]        in_idx;

  // entry being sifted and the hole it travels through
  entry_t        x;
  logic [IW-1:0] i;

  logic [SW-1:0]    size;
  logic [CNT_W-1:0] heads;
  logic             merge;
  logic [ARR_W-1:0] requested;
  logic [CNT_W-1:0] array_count;

  logic [CNT_W-1:0] heads_inc;
  logic [CNT_W-1:0] eff_count;
  logic [SW-1:0]    size_dec;
  logic [IW-1:0]    i_dec;
  logic [IW-1:0]    parent;
  logic [CIW-1:0]   l_idx;
  logic [CIW-1:0]   r_idx;
  logic [CIW-1:0]   size_ext;
  logic             l_ok;
  logic             r_ok;
  logic             take_l;
  logic             take_r;
  logic signed [VAL_W-1:0] best_val;
  entry_t           best_child;
  logic [CIW-1:0]   best_idx;

  logic               ram_we;
  logic [IW-1:0]      raddr_a;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata_a;
  logic [ENTRY_W-1:0] rdata_b;
  entry_t             rd_a;
  entry_t             rd_b;

  assign rd_a = rdata_a;
  assign rd_b = rdata_b;

  assign heads_inc = heads + 1'b1;
  assign size_dec  = size - 1'b1;
  assign i_dec     = i - 1'b1;
  assign parent    = i_dec >> 1;
  assign l_idx     = {1'b0, i, 1'b1};
  assign r_idx     = l_idx + 1'b1;
  assign size_ext  = {{(CIW - SW){1'b0}}, size};

  // count 0 acts as 1, anything above the heap depth or 16 is clamped
  always_comb begin
    if (array_count == '0) eff_count = CNT_W'(1);
    else if (array_count > CNT_W'(CAP)) eff_count = CNT_W'(CAP);
    else eff_count = array_count;
  end

  // parent wins ties, left wins over an equal right
  always_comb begin
    l_ok       = l_idx < size_ext;
    r_ok       = r_idx < size_ext;
    take_l     = l_ok && ($signed(rd_a.value) < $signed(x.value));
    best_val   = take_l ? rd_a.value : x.value;
    take_r     = r_ok && ($signed(rd_b.value) < $signed(best_val));
    best_child = take_r ? rd_b : rd_a;
    best_idx   = take_r ? r_idx : l_idx;
  end

  always_comb begin
    status.req_err     = in_idx != requested;
    status.merge_phase = merge;
    status.cmd_end     = in_cmd;
    status.heap_full   = size == SW'(MAX_ARRAYS);
    status.size_zero   = size == '0;
    status.size_one    = size == SW'(1);
    status.at_root     = i == '0;
    status.x_less_a    = $signed(x.value) < $signed(rd_a.value);
    status.child_moves = take_l || take_r;
    status.report_due  = merge || (heads >= eff_count);
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_ROOT:   raddr_a = '0;
      RD_LAST:   raddr_a = size_dec[IW-1:0];
      RD_PARENT: raddr_a = parent;
      RD_LEFT:   raddr_a = l_idx[IW-1:0];
      default:   raddr_a = '0;
    endcase
  end

  assign ram_we = cmd.wr_x || cmd.up_move || cmd.dn_move;

  always_comb begin
    if (cmd.up_move) wdata = rd_a;
    else if (cmd.dn_move) wdata = best_child;
    else wdata = x;
  end

  kwhm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ARRAYS)
  ) u_heap (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (i),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (r_idx[IW-1:0]),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      size         <= '0;
      heads        <= '0;
      merge        <= 1'b0;
      requested    <= '0;
      array_count  <= COUNT_RESET;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_err || cmd.emit_report;
      if (cfg_we) array_count <= cfg_data;
      if (cmd.fill_step) begin
        heads     <= heads_inc;
        requested <= heads_inc[ARR_W-1:0];
      end
      if (cmd.push) size <= size + 1'b1;
      if (cmd.drop) size <= size_dec;
      if (cmd.emit_report) begin
        if (size == '0) begin
          merge     <= 1'b0;
          heads     <= '0;
          requested <= '0;
        end else begin
          merge     <= 1'b1;
          requested <= rd_a.source;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_cmd <= command;
      in_val <= element_value;
      in_idx <= array_index;
    end
    if (cmd.push) begin
      x.value  <= in_val;
      x.source <= in_idx;
      i        <= size[IW-1:0];
    end
    if (cmd.up_move) i <= parent;
    // replace keeps the root's source, removal takes the last entry whole
    if (cmd.load_x) begin
      x.value  <= in_cmd ? rd_a.value : in_val;
      x.source <= rd_a.source;
      i        <= '0;
    end
    if (cmd.dn_move) i <= best_idx[IW-1:0];
    if (cmd.emit_err) begin
      min_value  <= '0;
      next_array <= requested;
      done_res   <= 1'b0;
      error      <= 1'b1;
    end
    if (cmd.emit_report) begin
      error <= 1'b0;
      if (size == '0) begin
        min_value  <= '0;
        next_array <= '0;
        done_res   <= 1'b1;
      end else begin
        min_value  <= rd_a.value;
        next_array <= rd_a.source;
        done_res   <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/kwhm_checker.sv
`include "k_way_heap_merge_core_assert.svh"

module kwhm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              busy,
  input logic                              result_valid,
  input logic signed [kwhm_pkg::VAL_W-1:0] min_value,
  input logic [kwhm_pkg::ARR_W-1:0]        next_array,
  input logic                              done_res,
  input logic                              error
);

  `KWHM_ASSERT_NOW(a_done_err_excl, result_valid, !(done_res && error))
  `KWHM_ASSERT_NOW(a_flag_zero_min, result_valid && (done_res || error), min_value == '0)
  `KWHM_ASSERT_NOW(a_done_restarts, result_valid && done_res, next_array == '0)
  `KWHM_ASSERT_NOW(a_result_idle, result_valid, !busy)
  `KWHM_ASSERT_NEXT(a_single_result, result_valid, !result_valid)

endmodule

bind k_way_heap_merge_core kwhm_checker u_kwhm_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .min_value    (min_value),
  .next_array   (next_array),
  .done_res     (done_res),
  .error        (error)
);
